@@ rtl/core/bdnr_pkg.sv @@
// ----------------------------------------------------------------------------
// bdnr_pkg
// Shared types, constants and the glyph table for the big-digit number
// renderer: payload structs, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bdnr_pkg;

   localparam int MAX_DIGITS_DEF  = 10;
   localparam int CELLS_PER_ROW   = 3;
   localparam int CELLS_PER_DIGIT = 2 * CELLS_PER_ROW;

   localparam logic [7:0]  BLANK_ROM_CODE = 8'd255;
   localparam logic [7:0]  SPACE_CODE     = 8'd32;
   localparam logic [2:0]  CELL_LAST      = 3'(CELLS_PER_DIGIT - 1);
   localparam logic [2:0]  CELL_LOWER     = 3'(CELLS_PER_ROW);
   localparam logic [7:0]  DIGIT_STRIDE   = 8'(CELLS_PER_ROW);
   localparam logic [31:0] RECIP_TEN      = 32'hCCCC_CCCD;

   typedef struct packed {
      logic [31:0] value;
      logic [7:0]  start_column;
      logic [7:0]  start_row;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_column;
      logic [7:0] cell_row;
      logic [7:0] char_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic emit_last;
      logic out_free;
   } status_type;

   function automatic logic [7:0] glyph_rom(input logic [3:0] digit, input logic [2:0] slot);
      logic [47:0] row;
      logic [7:0]  code;
      case (digit)
         4'd1:    row = {8'd255, 8'd1, 8'd2, 8'd255, 8'd255, 8'd5};
         4'd2:    row = {8'd6,   8'd6, 8'd2, 8'd3,   8'd7,   8'd7};
         4'd3:    row = {8'd6,   8'd6, 8'd2, 8'd7,   8'd7,   8'd5};
         4'd4:    row = {8'd3,   8'd4, 8'd2, 8'd255, 8'd255, 8'd5};
         4'd5:    row = {8'd0,   8'd6, 8'd6, 8'd7,   8'd7,   8'd5};
         4'd6:    row = {8'd0,   8'd6, 8'd6, 8'd3,   8'd7,   8'd5};
         4'd7:    row = {8'd1,   8'd1, 8'd2, 8'd255, 8'd0,   8'd255};
         4'd8:    row = {8'd0,   8'd6, 8'd2, 8'd3,   8'd7,   8'd5};
         4'd9:    row = {8'd0,   8'd6, 8'd2, 8'd255, 8'd255, 8'd5};
         default: row = {8'd0,   8'd1, 8'd2, 8'd3,   8'd4,   8'd5};
      endcase
      case (slot)
         3'd0:    code = row[47:40];
         3'd1:    code = row[39:32];
         3'd2:    code = row[31:24];
         3'd3:    code = row[23:16];
         3'd4:    code = row[15:8];
         3'd5:    code = row[7:0];
         default: code = BLANK_ROM_CODE;
      endcase
      return (code == BLANK_ROM_CODE) ? SPACE_CODE : code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/big_digit_number_renderer.sv @@
// ----------------------------------------------------------------------------
// big_digit_number_renderer
// Renders a 32-bit unsigned number as big decimal digits, six character-cell
// writes per digit, most significant digit first.
//
//   port group  direction  payload   meaning
//   req_*       in         req_type  number, start column, start row
//   rsp_*       out        rsp_type  one character-cell write
//
// A number is accepted, divided by ten once per digit with a 32x32 reciprocal
// multiply, and then written out cell by cell.
// Synchronous active-high reset clears the controller and the output valid.
// The last cell write waits in the output register while the next number is
// taken in; rsp_stall holds the cell sequence, req_stall is high while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module big_digit_number_renderer
   import bdnr_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   bdnr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bdnr_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/core/bdnr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdnr_ctrl
// Controller: accepts a number, runs the divide-by-ten steps, then paces the
// cell writes into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdnr_ctrl
   import bdnr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_step = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/bdnr_dpath.sv @@
// ----------------------------------------------------------------------------
// bdnr_dpath
// Datapath: reciprocal divide-by-ten, digit store, cell counters, glyph
// lookup and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdnr_dpath
   import bdnr_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output status_type   status,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [CNT_W-1:0] CNT_STOP = CNT_W'(MAX_DIGITS - 1);

   logic [31:0]      rem_ff;
   logic [7:0]       col_ff;
   logic [7:0]       row_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic [2:0]       cell_ff;
   logic [3:0]       digit_store [MAX_DIGITS];
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [63:0] prod;
   logic [31:0] quot;
   logic [3:0]  digit;
   logic [3:0]  cur_digit;
   logic        lower;
   logic [1:0]  offset;
   rsp_type     cell_out;

   // quotient by reciprocal multiply, digit from the low bits of value - 10*q
   assign prod  = 64'(rem_ff) * 64'(RECIP_TEN);
   assign quot  = {3'b000, prod[63:35]};
   assign digit = rem_ff[3:0] - {quot[2:0], 1'b0} - {quot[0], 3'b000};

   assign cur_digit = digit_store[ptr_ff];
   assign lower     = (cell_ff >= CELL_LOWER);
   assign offset    = lower ? 2'(cell_ff - CELL_LOWER) : cell_ff[1:0];

   always_comb begin
      cell_out.cell_column = col_ff + {6'b000000, offset};
      cell_out.cell_row    = row_ff + {7'b0000000, lower};
      cell_out.char_code   = glyph_rom(cur_digit, cell_ff);
      cell_out.last        = status.emit_last;
   end

   assign status.div_done  = (quot == 32'd0) || (cnt_ff == CNT_STOP);
   assign status.emit_last = (ptr_ff == '0) && (cell_ff == CELL_LAST);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ptr_ff  <= '0;
         cell_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff  <= '0;
         cell_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         ptr_ff <= cnt_ff[IDX_W-1:0];
      end else if (cmd.emit_step) begin
         if (cell_ff == CELL_LAST) begin
            cell_ff <= '0;
            ptr_ff  <= ptr_ff - IDX_W'(1);
         end else begin
            cell_ff <= cell_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= req_data.value;
         col_ff <= req_data.start_column;
         row_ff <= req_data.start_row;
      end else if (cmd.div_step) begin
         rem_ff <= quot;
      end else if (cmd.emit_step && (cell_ff == CELL_LAST)) begin
         col_ff <= col_ff + DIGIT_STRIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step) begin
         digit_store[cnt_ff[IDX_W-1:0]] <= digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         rsp_data_ff <= cell_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/bdnr_checker.sv @@
// ----------------------------------------------------------------------------
// bdnr_checker
// Port-level checks for the big-digit number renderer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdnr_checker
   import bdnr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic req_xfer;
   logic rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a taken number keeps the input side closed while its digits are worked out
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("input open in the cycle after a transfer");

   // a cell that is not the last of its number means the block is still busy
   a_busy_mid_number: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_data.last |-> req_stall)
      else $error("input open in the middle of a number");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind big_digit_number_renderer bdnr_checker u_bdnr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ verif/tb_big_digit_number_renderer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_big_digit_number_renderer
// Self-checking bench for the big-digit number renderer. A driver and a
// monitor run as clocked processes; every number accepted on the request
// side is expanded into its expected cell writes, and each response transfer
// is checked field by field against the oldest outstanding cell write.
// Directed numbers cover every digit, zero, the widest value and wrapping
// coordinates, followed by random numbers under several idle/stall mixes,
// a long receiver hold-off, and pauses until all cells have drained.
// ----------------------------------------------------------------------------

module tb_big_digit_number_renderer
   import bdnr_pkg::*;
();

   localparam logic [0:9][0:5][7:0] GLYPH_CODES = {
      8'd0,   8'd1, 8'd2, 8'd3,   8'd4,   8'd5,
      8'd255, 8'd1, 8'd2, 8'd255, 8'd255, 8'd5,
      8'd6,   8'd6, 8'd2, 8'd3,   8'd7,   8'd7,
      8'd6,   8'd6, 8'd2, 8'd7,   8'd7,   8'd5,
      8'd3,   8'd4, 8'd2, 8'd255, 8'd255, 8'd5,
      8'd0,   8'd6, 8'd6, 8'd7,   8'd7,   8'd5,
      8'd0,   8'd6, 8'd6, 8'd3,   8'd7,   8'd5,
      8'd1,   8'd1, 8'd2, 8'd255, 8'd0,   8'd255,
      8'd0,   8'd6, 8'd2, 8'd3,   8'd7,   8'd5,
      8'd0,   8'd6, 8'd2, 8'd255, 8'd255, 8'd5
   };
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_numbers [$];
   rsp_type expected_cells [$];
   rsp_type want_cell;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      hold_left = 0;
   logic    hold_trigger = 1'b0;
   int      mismatch_count = 0;

   big_digit_number_renderer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void render_number(req_type item);
      logic [3:0]  digits [MAX_DIGITS_DEF];
      logic [31:0] rest;
      logic [3:0]  d;
      logic [7:0]  code;
      int          count;
      int          total;
      int          n;
      int          off;
      logic        lower;
      rsp_type     cell_out;
      rest = item.value;
      count = 0;
      if (rest == 0) begin
         digits[0] = 4'd0;
         count = 1;
      end else begin
         while (rest != 0 && count < MAX_DIGITS_DEF) begin
            digits[count] = 4'(rest % 10);
            rest = rest / 10;
            count++;
         end
      end
      total = count * CELLS_PER_DIGIT;
      n = 0;
      for (int pos = 0; pos < count; pos++) begin
         d = digits[count - 1 - pos];
         if (d > 4'd9) d = 4'd0;
         for (int slot = 0; slot < CELLS_PER_DIGIT; slot++) begin
            code = GLYPH_CODES[d][slot];
            lower = (slot >= CELLS_PER_ROW);
            off = lower ? slot - CELLS_PER_ROW : slot;
            cell_out.cell_column = 8'(int'(item.start_column) + CELLS_PER_ROW * pos + off);
            cell_out.cell_row    = 8'(int'(item.start_row) + (lower ? 1 : 0));
            cell_out.char_code   = (code == BLANK_ROM_CODE) ? SPACE_CODE : code;
            cell_out.last        = (n + 1 == total);
            expected_cells.push_back(cell_out);
            n++;
         end
      end
   endfunction

   function automatic logic [7:0] random_coord();
      if ($urandom_range(3) == 0) return 8'($urandom_range(255, 240));
      return 8'($urandom());
   endfunction

   function automatic req_type random_number();
      req_type     item;
      int unsigned digits;
      longint      lo;
      longint      hi;
      if ($urandom_range(3) == 0) begin
         item.value = $urandom();
      end else begin
         digits = $urandom_range(10, 1);
         lo = 1;
         for (int k = 1; k < digits; k++) lo = lo * 10;
         hi = (digits == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
         if (digits == 1) lo = 0;
         item.value = $urandom_range(int'(hi), int'(lo));
      end
      item.start_column = random_coord();
      item.start_row    = random_coord();
      return item;
   endfunction

   function automatic req_type make_number(logic [31:0] value, logic [7:0] col,
                                           logic [7:0] row);
      req_type item;
      item.value        = value;
      item.start_column = col;
      item.start_row    = row;
      return item;
   endfunction

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s): expected col=%0d row=%0d code=%0d last=%0d",
                  what, want.cell_column, want.cell_row, want.char_code, want.last,
                  ", got col=%0d row=%0d code=%0d last=%0d",
                  got.cell_column, got.cell_row, got.char_code, got.last);
   endtask

   task automatic wait_idle();
      while (pending_numbers.size() != 0 || req_valid || expected_cells.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int idle, int stall, int count);
      @(negedge clock);
      idle_pct = idle;
      stall_pct = stall;
      repeat (count) pending_numbers.push_back(random_number());
      wait_idle();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) render_number(req_data);
         if (!(req_valid && req_stall)) begin
            if (pending_numbers.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data  <= pending_numbers.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off counter
   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_trigger) hold_left <= HOLD_CYCLES;
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               report_mismatch("unexpected transfer", '0, rsp_data);
            end else begin
               want_cell = expected_cells.pop_front();
               if (rsp_data.cell_column !== want_cell.cell_column ||
                   rsp_data.cell_row !== want_cell.cell_row ||
                   rsp_data.char_code !== want_cell.char_code ||
                   rsp_data.last !== want_cell.last)
                  report_mismatch("cell", want_cell, rsp_data);
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      pending_numbers.push_back(make_number(32'd0, 8'd0, 8'd0));
      pending_numbers.push_back(make_number(32'd0, 8'd255, 8'd255));
      pending_numbers.push_back(make_number(32'd1, 8'd10, 8'd1));
      pending_numbers.push_back(make_number(32'd9, 8'd254, 8'd0));
      pending_numbers.push_back(make_number(32'd10, 8'd0, 8'd255));
      pending_numbers.push_back(make_number(32'd99, 8'd253, 8'd2));
      pending_numbers.push_back(make_number(32'd100, 8'd5, 8'd7));
      pending_numbers.push_back(make_number(32'd1234567890, 8'd0, 8'd0));
      pending_numbers.push_back(make_number(32'd987654321, 8'd250, 8'd254));
      pending_numbers.push_back(make_number(32'hFFFF_FFFF, 8'd255, 8'd255));
      pending_numbers.push_back(make_number(32'hFFFF_FFFF, 8'd0, 8'd0));
      pending_numbers.push_back(make_number(32'h8000_0000, 8'd128, 8'd128));
      pending_numbers.push_back(make_number(32'd1000000000, 8'd230, 8'd100));
      pending_numbers.push_back(make_number(32'd9999999, 8'd1, 8'd254));
      pending_numbers.push_back(make_number(32'h5555_5555, 8'hAA, 8'h55));
      pending_numbers.push_back(make_number(32'hAAAA_AAAA, 8'h55, 8'hAA));
      wait_idle();

      run_phase(0, 0, 70);
      run_phase(85, 0, 70);
      run_phase(0, 85, 70);
      run_phase(6, 6, 70);

      // receiver holds off while the sender keeps offering numbers
      @(negedge clock);
      idle_pct = 0;
      stall_pct = 6;
      repeat (40) pending_numbers.push_back(random_number());
      @(posedge clock);
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      wait_idle();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_cells.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
